### sv/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = CFG_IDX_W'(2);

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = CFG_W'(6);
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = CFG_W'(8);
  localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = CFG_W'(8);

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic cmp;
    logic upd;
    logic clr;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/set_assoc_lru_cache_tags.sv
// each item makes one row memory round trip before a further item is taken
//   (read the set, compare the ways, write the set back), in S_IDLE, S_CMP and S_UPD;
// the result register is loaded as the set is written back
// a further item is taken while a result still waits; its write-back then waits on out_ready
// reset is synchronous and active low; it clears the valid bits by a pass over all MAX_SETS
//   sets, one set a cycle, with in_ready low throughout
module set_assoc_lru_cache_tags #(
  parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [salc_pkg::ADDR_W-1:0]    in_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [salc_pkg::CNT_W-1:0]     out_hit_count,
  output logic [salc_pkg::CNT_W-1:0]     out_miss_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]     cfg_data
);

  import salc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  salc_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_address     (in_address),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_hit_count  (out_hit_count),
    .out_miss_count (out_miss_count)
  );

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  // the set write-back only lands when the output register can take the result
  a_upd_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> stat.out_free)
    else $error("result loaded over a waiting one");

  a_upd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> out_valid)
    else $error("result lost after update");

  // no item taken during the clearing pass
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_ready)
    else $error("item accepted while clearing");

endmodule

### sv/salc_ram.sv
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/salc_ctrl.sv
module salc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  salc_pkg::dp_stat_t stat,
  output salc_pkg::dp_cmd_t  cmd
);

  import salc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CMP   = 4'b0100,
    S_UPD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (stat.out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/salc_dp.sv
module salc_dp #(
  parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  salc_pkg::dp_cmd_t                cmd,
  output salc_pkg::dp_stat_t               stat,
  input  logic [salc_pkg::ADDR_W-1:0]      in_address,
  input  logic                             cfg_valid,
  input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [salc_pkg::CNT_W-1:0]       out_hit_count,
  output logic [salc_pkg::CNT_W-1:0]       out_miss_count
);

  import salc_pkg::*;

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W  = $clog2(MAX_WAYS + 1);
  localparam int ROW_W  = MAX_WAYS * (TAG_W + AGE_W + 1);
  localparam int SH_W   = 5;
  localparam logic [CFG_W-1:0] IB_CAP   = CFG_W'($clog2(MAX_SETS + 1) - 1);
  localparam logic [CFG_W:0]   WAYS_MAX = (CFG_W + 1)'(MAX_WAYS);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(MAX_SETS - 1);

  // configuration
  logic [CFG_W-1:0] offset_bits_r;
  logic [CFG_W-1:0] index_bits_r;
  logic [CFG_W-1:0] ways_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_BITS_RST;
      index_bits_r  <= INDEX_BITS_RST;
      ways_in_use_r <= WAYS_IN_USE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits_r <= cfg_data;
        REG_INDEX_BITS:  index_bits_r  <= cfg_data;
        REG_WAYS_IN_USE: ways_in_use_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] ib_eff;
  logic [AGE_W-1:0] ways_eff;

  assign ib_eff = (index_bits_r > IB_CAP) ? IB_CAP : index_bits_r;

  always_comb begin
    if (ways_in_use_r == '0) begin
      ways_eff = AGE_W'(1);
    end else if ({1'b0, ways_in_use_r} > WAYS_MAX) begin
      ways_eff = AGE_W'(MAX_WAYS);
    end else begin
      ways_eff = AGE_W'(ways_in_use_r);
    end
  end

  // address split
  logic [ADDR_W-1:0] addr_sh;
  logic [ADDR_W-1:0] set_mask;
  logic [SET_W-1:0]  set_nxt;
  logic [TAG_W-1:0]  tag_nxt;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;

  assign addr_sh  = in_address >> offset_bits_r;
  assign set_mask = (ADDR_W'(1) << ib_eff) - ADDR_W'(1);
  assign set_nxt  = SET_W'(addr_sh & set_mask);
  assign tag_nxt  = TAG_W'(in_address >> (SH_W'(offset_bits_r) + SH_W'(ib_eff)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r <= set_nxt;
      tag_r <= tag_nxt;
    end
  end

  // set row storage
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] new_row;
  logic [SET_W-1:0] clr_cnt_r;
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;

  assign ram_we    = cmd.clr | cmd.upd;
  assign ram_waddr = cmd.clr ? clr_cnt_r : set_r;
  assign wr_row    = cmd.clr ? '0 : new_row;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_row),
    .re    (cmd.load),
    .raddr (set_nxt),
    .rdata (rd_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  assign stat.clr_last = (clr_cnt_r == SET_LAST);

  logic [MAX_WAYS-1:0][TAG_W-1:0] row_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0] row_age;
  logic [MAX_WAYS-1:0]            row_vld;
  logic [MAX_WAYS-1:0]            in_use;

  assign {row_vld, row_age, row_tag} = rd_row;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (AGE_W'(w) < ways_eff);
    end
  end

  // way compare and replacement choice
  logic             hit_nxt;
  logic [WAY_W-1:0] hit_way;
  logic             free_f;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] vic_way;
  logic [WAY_W-1:0] tgt_nxt;
  logic [AGE_W-1:0] limit_nxt;
  logic             all_nxt;

  always_comb begin
    hit_nxt  = 1'b0;
    hit_way  = '0;
    free_f   = 1'b0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && row_vld[w] && (row_tag[w] == tag_r)) begin
        hit_nxt = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (in_use[w] && !row_vld[w]) begin
        free_f   = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    vic_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (row_age[w] > row_age[vic_way])) begin
        vic_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (hit_nxt) begin
      tgt_nxt   = hit_way;
      limit_nxt = row_age[hit_way];
      all_nxt   = 1'b0;
    end else if (free_f) begin
      tgt_nxt   = free_way;
      limit_nxt = '0;
      all_nxt   = 1'b1;
    end else begin
      tgt_nxt   = vic_way;
      limit_nxt = row_age[vic_way];
      all_nxt   = 1'b0;
    end
  end

  logic             hit_r;
  logic [WAY_W-1:0] tgt_r;
  logic [AGE_W-1:0] limit_r;
  logic             all_r;

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hit_r   <= hit_nxt;
      tgt_r   <= tgt_nxt;
      limit_r <= limit_nxt;
      all_r   <= all_nxt;
    end
  end

  // row update
  logic [MAX_WAYS-1:0][TAG_W-1:0] new_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0] new_age;
  logic [MAX_WAYS-1:0]            new_vld;

  always_comb begin
    new_tag = row_tag;
    new_vld = row_vld;
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_age[w] = row_age[w];
      if (in_use[w] && row_vld[w] && (row_age[w] < ways_eff) &&
          (all_r || (row_age[w] < limit_r))) begin
        new_age[w] = row_age[w] + AGE_W'(1);
      end
    end
    new_tag[tgt_r] = tag_r;
    new_age[tgt_r] = AGE_W'(1);
    new_vld[tgt_r] = 1'b1;
  end

  assign new_row = {new_vld, new_age, new_tag};

  // running totals and result register
  logic [CNT_W-1:0] hit_total_r;
  logic [CNT_W-1:0] miss_total_r;
  logic [CNT_W-1:0] hit_total_nxt;
  logic [CNT_W-1:0] miss_total_nxt;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [CNT_W-1:0] out_hit_count_r;
  logic [CNT_W-1:0] out_miss_count_r;

  assign hit_total_nxt  = hit_r ? hit_total_r + CNT_W'(1) : hit_total_r;
  assign miss_total_nxt = hit_r ? miss_total_r : miss_total_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r  <= '0;
      miss_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.upd) begin
        hit_total_r  <= hit_total_nxt;
        miss_total_r <= miss_total_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_hit_r        <= hit_r;
      out_hit_count_r  <= hit_total_nxt;
      out_miss_count_r <= miss_total_nxt;
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_hit_count  = out_hit_count_r;
  assign out_miss_count = out_miss_count_r;

endmodule
